// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fxfft_pkg.sv =====
package fxfft_pkg;

    localparam int MAX_LOG2_POINTS_DEF = 6;
    localparam logic [2:0] LOG2_POINTS_RESET = 3'd6;
    localparam int ROM_QUARTER = 64;

    typedef struct packed {
        logic signed [7:0] sample_re;
        logic signed [7:0] sample_im;
    } t_fft_in;

    typedef struct packed {
        logic [5:0]        bin_index;
        logic signed [7:0] bin_re;
        logic signed [7:0] bin_im;
        logic [2:0]        scale_count;
        logic              last_bin;
    } t_fft_out;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_RD,
        S_MUL,
        S_WRP,
        S_WRI,
        S_EM_RD,
        S_EM_WAIT,
        S_EM_OUT
    } t_fft_state;

    typedef enum logic {
        REG_LOG2_POINTS  = 1'b0,
        REG_INVERSE_MODE = 1'b1
    } t_reg_index;

    localparam logic signed [7:0] SINE_ROM [192] = '{
        8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd15, 8'sd18, 8'sd21,
        8'sd24, 8'sd28, 8'sd31, 8'sd34, 8'sd37, 8'sd40, 8'sd43, 8'sd46,
        8'sd48, 8'sd51, 8'sd54, 8'sd57, 8'sd60, 8'sd63, 8'sd65, 8'sd68,
        8'sd71, 8'sd73, 8'sd76, 8'sd78, 8'sd81, 8'sd83, 8'sd85, 8'sd88,
        8'sd90, 8'sd92, 8'sd94, 8'sd96, 8'sd98, 8'sd100, 8'sd102, 8'sd104,
        8'sd106, 8'sd108, 8'sd109, 8'sd111, 8'sd112, 8'sd114, 8'sd115, 8'sd117,
        8'sd118, 8'sd119, 8'sd120, 8'sd121, 8'sd122, 8'sd123, 8'sd124, 8'sd124,
        8'sd125, 8'sd126, 8'sd126, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127,
        8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd126, 8'sd126,
        8'sd125, 8'sd124, 8'sd124, 8'sd123, 8'sd122, 8'sd121, 8'sd120, 8'sd119,
        8'sd118, 8'sd117, 8'sd115, 8'sd114, 8'sd112, 8'sd111, 8'sd109, 8'sd108,
        8'sd106, 8'sd104, 8'sd102, 8'sd100, 8'sd98, 8'sd96, 8'sd94, 8'sd92,
        8'sd90, 8'sd88, 8'sd85, 8'sd83, 8'sd81, 8'sd78, 8'sd76, 8'sd73,
        8'sd71, 8'sd68, 8'sd65, 8'sd63, 8'sd60, 8'sd57, 8'sd54, 8'sd51,
        8'sd48, 8'sd46, 8'sd43, 8'sd40, 8'sd37, 8'sd34, 8'sd31, 8'sd28,
        8'sd24, 8'sd21, 8'sd18, 8'sd15, 8'sd12, 8'sd9, 8'sd6, 8'sd3,
        8'sd0, -8'sd3, -8'sd6, -8'sd9, -8'sd12, -8'sd15, -8'sd18, -8'sd21,
        -8'sd24, -8'sd28, -8'sd31, -8'sd34, -8'sd37, -8'sd40, -8'sd43, -8'sd46,
        -8'sd48, -8'sd51, -8'sd54, -8'sd57, -8'sd60, -8'sd63, -8'sd65, -8'sd68,
        -8'sd71, -8'sd73, -8'sd76, -8'sd78, -8'sd81, -8'sd83, -8'sd85, -8'sd88,
        -8'sd90, -8'sd92, -8'sd94, -8'sd96, -8'sd98, -8'sd100, -8'sd102, -8'sd104,
        -8'sd106, -8'sd108, -8'sd109, -8'sd111, -8'sd112, -8'sd114, -8'sd115, -8'sd117,
        -8'sd118, -8'sd119, -8'sd120, -8'sd121, -8'sd122, -8'sd123, -8'sd124, -8'sd124,
        -8'sd125, -8'sd126, -8'sd126, -8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd127
    };

    // product in Q-format: floor shift by 6, then halve rounding to nearest
    function automatic logic signed [7:0] round_prod(input logic signed [15:0] p);
        logic [9:0] c;
        c = p[15:6];
        return 8'(c[8:1] + {7'd0, c[0]});
    endfunction

    // magnitude above 63, minus 64 included
    function automatic logic is_big(input logic [7:0] v);
        return (v[7] ^ v[6]) | (v == 8'hc0);
    endfunction

endpackage

// ===== hdl/fixed_point_radix2_fft_unit.sv =====
// fixed-point radix-2 decimation-in-time fft, complex 8-bit q1.7 samples
// input channel: i_in_valid / o_in_stall carry one complex sample per transaction
// output channel: o_out_valid / i_out_stall carry one bin per transaction
// apb port: register 0 at 0x0 is log2_points (clamped to 1..MAX_LOG2_POINTS),
// register 1 at 0x4 is inverse_mode; a write drops any partial frame
// samples are written straight to their bit-reversed address while loading,
// one per cycle, for a frame of n = 2^log2_points samples
// after the last sample the in-place store runs log2_points passes, each a
// setup state plus n/2 butterflies, each stepping through read, multiply, write upper
// and write lower, sharing the single write port of the store
// bins then leave in index order, each read from the store, registered, then offered until taken
// a stall holds the bin register and the whole sequencer in place
// input stall stays high from the last sample until the final bin is taken
// reset: length 64, forward mode, empty frame; store contents are not cleared
module fixed_point_radix2_fft_unit
    import fxfft_pkg::*;
#(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_fft_in     i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_fft_out    o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "assert_macros.svh"

    localparam int AW = MAX_LOG2_POINTS;
    localparam int DEPTH = 1 << AW;
    localparam int CW = AW + 1;
    localparam int SW = $clog2(MAX_LOG2_POINTS + 1);

    // in-place complex store {re, im}
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_a;
    logic [15:0] r_rd_b;

    t_fft_state r_state, n_state;

    logic [2:0]    r_log2;
    logic          r_inv;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_s;
    logic [AW-1:0] r_b;
    logic [AW-1:0] r_k;
    logic          r_big;
    logic          r_halve;
    logic [2:0]    r_scale;

    logic signed [7:0]  r_wr, r_wi;
    logic signed [15:0] r_prr, r_pii, r_pri, r_pir;
    logic signed [7:0]  r_qr, r_qi;
    logic [15:0]        r_sum;
    t_fft_out           r_out;

    logic [2:0]    m_eff;
    logic [CW-1:0] n_pts;
    logic          cfg_wr;
    logic          in_acc;
    logic          out_acc;
    logic          load_last;
    logic          bf_last;
    logic          pass_last;
    logic          emit_last;

    logic [AW-1:0] rev_full;
    logic [AW-1:0] load_addr;
    logic [AW-1:0] l_span, low_mask, g_idx, bi, bp;
    logic [14:0]   j_wide;
    logic [7:0]    j_idx;
    logic signed [7:0] w_sin, w_cos, w_im;

    logic signed [7:0] tr, ti, d_re, d_im, s_re, s_im;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;
    logic [AW-1:0]   raddr_a;

    // effective length, out-of-range codes clamp
    always_comb begin
        if (r_log2 == 3'd0) begin
            m_eff = 3'd1;
        end else if (int'(r_log2) > MAX_LOG2_POINTS) begin
            m_eff = 3'(MAX_LOG2_POINTS);
        end else begin
            m_eff = r_log2;
        end
    end

    assign n_pts = CW'(1) << m_eff;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign load_last = (r_cnt == n_pts - CW'(1));
    assign bf_last   = (r_b == AW'((n_pts >> 1) - CW'(1)));
    assign pass_last = (r_s == SW'(m_eff - 3'd1));
    assign emit_last = ({1'b0, r_k} == n_pts - CW'(1));

    // bit-reversed load address over the current length
    always_comb begin
        for (int t = 0; t < AW; t++) begin
            rev_full[AW-1-t] = r_cnt[t];
        end
    end
    assign load_addr = rev_full >> (AW - int'(m_eff));

    // butterfly addresses: insert a zero at bit s of the butterfly count
    assign l_span   = AW'(1) << r_s;
    assign low_mask = l_span - AW'(1);
    assign g_idx    = r_b & low_mask;
    assign bi       = ((r_b & ~low_mask) << 1) | g_idx;
    assign bp       = bi | l_span;

    // twiddle angle (g << (7 - s)) of a 256-point turn
    assign j_wide = 15'(g_idx) << (4'd7 - 4'(r_s));
    assign j_idx  = {1'b0, j_wide[6:0]};
    assign w_cos  = SINE_ROM[j_idx + 8'(ROM_QUARTER)];
    assign w_sin  = SINE_ROM[j_idx];
    assign w_im   = r_inv ? w_sin : -w_sin;

    // butterfly arithmetic from registered products, all sums wrap to 8 bits
    assign tr   = round_prod(r_prr) - round_prod(r_pii);
    assign ti   = round_prod(r_pri) + round_prod(r_pir);
    assign d_re = r_qr - tr;
    assign d_im = r_qi - ti;
    assign s_re = r_qr + tr;
    assign s_im = r_qi + ti;

    // store write port
    always_comb begin
        we    = 1'b0;
        waddr = bi;
        wdata = r_sum;
        case (r_state)
            S_LOAD: begin
                we    = in_acc;
                waddr = load_addr;
                wdata = {i_in.sample_re, i_in.sample_im};
            end
            S_WRP: begin
                we    = 1'b1;
                waddr = bp;
                wdata = {d_re, d_im};
            end
            S_WRI: begin
                we    = 1'b1;
                waddr = bi;
                wdata = r_sum;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign raddr_a = (r_state == S_EM_RD) ? r_k : bi;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[bp];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && load_last) begin
                    n_state = S_PASS;
                end
            end
            S_PASS:    n_state = S_RD;
            S_RD:      n_state = S_MUL;
            S_MUL:     n_state = S_WRP;
            S_WRP:     n_state = S_WRI;
            S_WRI: begin
                if (!bf_last) begin
                    n_state = S_RD;
                end else if (pass_last) begin
                    n_state = S_EM_RD;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_EM_RD:   n_state = S_EM_WAIT;
            S_EM_WAIT: n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (!i_out_stall) begin
                    n_state = emit_last ? S_LOAD : S_EM_RD;
                end
            end
            default:   n_state = S_LOAD;
        endcase
    end

    // channel outputs
    always_comb begin
        o_in_stall  = (r_state != S_LOAD);
        o_out_valid = (r_state == S_EM_OUT);
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_log2  <= LOG2_POINTS_RESET;
            r_inv   <= 1'b0;
            r_cnt   <= '0;
            r_s     <= '0;
            r_b     <= '0;
            r_k     <= '0;
            r_big   <= 1'b0;
            r_halve <= 1'b1;
            r_scale <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (t_reg_index'(paddr[2]))
                    REG_LOG2_POINTS:  r_log2 <= pwdata[2:0];
                    REG_INVERSE_MODE: r_inv  <= pwdata[0];
                    default:          r_inv  <= r_inv;
                endcase
                r_cnt <= '0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc && !cfg_wr) begin
                        r_cnt <= load_last ? '0 : r_cnt + CW'(1);
                        r_big <= ((r_cnt == '0) ? 1'b0 : r_big)
                                 | is_big(i_in.sample_re) | is_big(i_in.sample_im);
                        r_s   <= '0;
                        r_b   <= '0;
                    end
                end
                S_PASS: begin
                    // inverse mode halves only when the loaded frame or the last pass left a large value
                    r_halve <= !r_inv || r_big;
                    r_scale <= ((r_s == '0) ? 3'd0 : r_scale) + {2'd0, r_inv && r_big};
                    r_big   <= 1'b0;
                end
                S_WRP: begin
                    r_big <= r_big | is_big(d_re) | is_big(d_im);
                end
                S_WRI: begin
                    r_big <= r_big | is_big(r_sum[15:8]) | is_big(r_sum[7:0]);
                    if (bf_last) begin
                        r_b <= '0;
                        r_s <= r_s + SW'(1);
                        r_k <= '0;
                    end else begin
                        r_b <= r_b + AW'(1);
                    end
                end
                S_EM_OUT: begin
                    if (!i_out_stall && !emit_last) begin
                        r_k <= r_k + AW'(1);
                    end
                end
                default: begin
                    r_b <= r_b;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RD: begin
                r_wr <= r_halve ? (w_cos >>> 1) : w_cos;
                r_wi <= r_halve ? (w_im >>> 1) : w_im;
            end
            S_MUL: begin
                r_prr <= r_wr * $signed(r_rd_b[15:8]);
                r_pii <= r_wi * $signed(r_rd_b[7:0]);
                r_pri <= r_wr * $signed(r_rd_b[7:0]);
                r_pir <= r_wi * $signed(r_rd_b[15:8]);
                r_qr  <= r_halve ? ($signed(r_rd_a[15:8]) >>> 1) : $signed(r_rd_a[15:8]);
                r_qi  <= r_halve ? ($signed(r_rd_a[7:0]) >>> 1) : $signed(r_rd_a[7:0]);
            end
            S_WRP: begin
                r_sum <= {s_re, s_im};
            end
            S_EM_WAIT: begin
                r_out.bin_index   <= 6'(r_k);
                r_out.bin_re      <= r_rd_a[15:8];
                r_out.bin_im      <= r_rd_a[7:0];
                r_out.scale_count <= r_scale;
                r_out.last_bin    <= emit_last;
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

    // apb read side
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'd0, r_inv} : {29'd0, r_log2};

    // no sample may be taken while a bin is on offer
    `ASSERT_ALWAYS(a_no_load_while_emit, !(o_out_valid && !o_in_stall),
        "input open during emission")
    // the final bin releases the input side
    `ASSERT_NEXT(a_last_reopens, out_acc && o_out.last_bin, !o_in_stall,
        "input not reopened after final bin")
    // emitted index always within the frame
    `ASSERT_ALWAYS(a_index_in_frame, !o_out_valid || ({1'b0, r_k} < n_pts),
        "bin index beyond frame length")

endmodule

// ===== bench/testbench.sv =====
module testbench
    import fxfft_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // sample and bin channels
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_fft_in  i_in = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_fft_out o_out;

    // register port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fixed_point_radix2_fft_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state: frame store, fill level and register copies
    int       frame_re [64];
    int       frame_im [64];
    int       fill_level;
    int       len_reg;
    bit       inv_reg;
    t_fft_out bins_due [$];
    int       errors;
    int       idle_cycles;

    localparam int IDLE_LIMIT = 20000;

    function automatic int wrap_byte(int v);
        logic [7:0] b;
        b = v[7:0];
        return int'($signed(b));
    endfunction

    // floor division by a power of two
    function automatic int floor_shift(int v, int s);
        return v >>> s;
    endfunction

    function automatic int q_product(int a, int b);
        int c;
        c = floor_shift(a * b, 6);
        return wrap_byte(floor_shift(c, 1) + (c & 1));
    endfunction

    // run the in-place transform on the frame store, return scale count
    function automatic int run_transform(int m);
        int n, scale, k, l, g, i, r, t, j, wr, wi, p, tr, ti, qr, qi, a, b;
        bit halve;
        n = 1 << m;
        scale = 0;
        for (i = 0; i < n; i++) begin
            r = 0;
            for (int bt = 0; bt < m; bt++)
                if ((i >> bt) & 1) r |= 1 << (m - 1 - bt);
            if (r > i) begin
                t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
                t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
            end
        end
        k = 7;
        for (l = 1; l < n; l <<= 1) begin
            halve = 1'b1;
            if (inv_reg) begin
                halve = 1'b0;
                for (i = 0; i < n; i++) begin
                    a = frame_re[i] < 0 ? -frame_re[i] : frame_re[i];
                    b = frame_im[i] < 0 ? -frame_im[i] : frame_im[i];
                    if (a > 63 || b > 63) halve = 1'b1;
                end
                if (halve) scale++;
            end
            for (g = 0; g < l; g++) begin
                j = (g << k) & 127;
                wr = SINE_ROM[j + 64];
                wi = -SINE_ROM[j];
                if (inv_reg) wi = -wi;
                if (halve) begin
                    wr = floor_shift(wr, 1);
                    wi = floor_shift(wi, 1);
                end
                for (i = g; i < n; i += 2 * l) begin
                    p = i + l;
                    tr = wrap_byte(q_product(wr, frame_re[p]) - q_product(wi, frame_im[p]));
                    ti = wrap_byte(q_product(wr, frame_im[p]) + q_product(wi, frame_re[p]));
                    qr = frame_re[i];
                    qi = frame_im[i];
                    if (halve) begin
                        qr = floor_shift(qr, 1);
                        qi = floor_shift(qi, 1);
                    end
                    frame_re[p] = wrap_byte(qr - tr);
                    frame_im[p] = wrap_byte(qi - ti);
                    frame_re[i] = wrap_byte(qr + tr);
                    frame_im[i] = wrap_byte(qi + ti);
                end
            end
            if (k > 0) k--;
        end
        return inv_reg ? scale : 0;
    endfunction

    // take one sample into the predicted frame, queue bins on frame end
    task automatic predict_sample(t_fft_in s);
        int m, n, scale;
        t_fft_out o;
        m = len_reg < 1 ? 1 : (len_reg > 6 ? 6 : len_reg);
        n = 1 << m;
        frame_re[fill_level & 63] = int'(s.sample_re);
        frame_im[fill_level & 63] = int'(s.sample_im);
        fill_level = (fill_level + 1) & 127;
        if (fill_level >= n) begin
            fill_level = 0;
            scale = run_transform(m);
            for (int b = 0; b < n; b++) begin
                o.bin_index   = 6'(b);
                o.bin_re      = 8'(frame_re[b]);
                o.bin_im      = 8'(frame_im[b]);
                o.scale_count = 3'(scale);
                o.last_bin    = (b == n - 1);
                bins_due.push_back(o);
            end
        end
    endtask

    // apb write, setup then access; pready is always high
    task automatic reg_write(t_reg_index idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_LOG2_POINTS) len_reg = int'(val[2:0]);
        else inv_reg = val[0];
        fill_level = 0;
    endtask

    // send one sample after a random gap, predict on acceptance
    task automatic send_sample(t_fft_in s);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= s;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(s);
    endtask

    // wait until all bins are out, plus a settling margin
    task automatic drain;
        i_in_valid <= 1'b0;
        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // random receiver stall, held per bin
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_left = $urandom_range(0, 4);
            i_out_stall <= (stall_left != 0);
        end else if (i_out_stall) begin
            stall_left--;
            i_out_stall <= (stall_left > 0);
        end
    end

    // bin checker and watchdog
    always @(posedge i_clk) begin
        t_fft_out want;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && !o_in_stall) idle_cycles = 0;
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                if (bins_due.size() == 0) begin
                    $display("%0t: unexpected bin %p", $realtime, o_out);
                    errors++;
                end else begin
                    want = bins_due.pop_front();
                    if (o_out !== want) begin
                        $display("%0t: bin mismatch expected %p actual %p",
                                 $realtime, want, o_out);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // directed rows: extremes of both fields, zero, plus and minus one, and 64 in both
    localparam int DIR_ROWS = 8;
    localparam logic [15:0] DIR_TABLE [DIR_ROWS] = '{
        16'h7f7f, 16'h8080, 16'h7f80, 16'h807f,
        16'h0000, 16'hff01, 16'h01ff, 16'h4040
    };

    task automatic random_frames(int count, int bias);
        t_fft_in s;
        for (int i = 0; i < count; i++) begin
            s = t_fft_in'(16'($urandom()));
            if (bias == 1) begin
                s.sample_re = 8'($signed(7'($urandom())) >>> 1);
                s.sample_im = 8'($signed(7'($urandom())) >>> 1);
            end
            send_sample(s);
        end
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        fill_level = 0;
        len_reg = 6;
        inv_reg = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: smallest length, forward then inverse
        reg_write(REG_LOG2_POINTS, 32'd1);
        reg_write(REG_INVERSE_MODE, 32'd0);
        foreach (DIR_TABLE[r]) send_sample(t_fft_in'(DIR_TABLE[r]));
        drain();
        reg_write(REG_INVERSE_MODE, 32'd1);
        foreach (DIR_TABLE[r]) send_sample(t_fft_in'(DIR_TABLE[r]));
        drain();
        // out-of-range lengths clamp; partial frame dropped by a write
        reg_write(REG_LOG2_POINTS, 32'd0);
        send_sample(t_fft_in'(16'h7f80));
        reg_write(REG_LOG2_POINTS, 32'd7);
        send_sample(t_fft_in'(16'h1234));
        reg_write(REG_LOG2_POINTS, 32'd2);
        for (int i = 0; i < 4; i++) send_sample(t_fft_in'(DIR_TABLE[i]));
        drain();

        // random phases across lengths and modes, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_LOG2_POINTS,
                      (ph == 0 || ph == 3) ? 32'd6 : 32'($urandom_range(1, 6)));
            reg_write(REG_INVERSE_MODE, 32'(ph & 1));
            random_frames((len_reg < 1 ? 2 : (1 << (len_reg > 6 ? 6 : len_reg))) * 2
                          + $urandom_range(0, 1) * 5, ph % 3 == 2);
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
